// File: rtl/bff_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bff_pkg
// Shared types and constants for the seeded FNV-1a Bloom filter unit.
// ----------------------------------------------------------------------------
package bff_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_CHECK = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [0:0] REG_FILTER_BITS = 1'd0;
  localparam logic [0:0] REG_HASH_COUNT  = 1'd1;

endpackage
`default_nettype wire

// File: rtl/bff_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bff_divider
// Restoring remainder unit: reduces a 32-bit hash modulo a divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module bff_divider #(
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [31:0]   dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      remainder
);

  logic [31:0] quo_r, quo_nxt;
  logic [DW:0] rem_r, rem_nxt;
  logic [DW:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [DW:0] trial;

  always_comb begin
    trial    = {rem_r[DW-1:0], quo_r[31]};
    quo_nxt  = {quo_r[30:0], 1'b0};
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 6'd32;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = (trial >= dvs_r) ? trial - dvs_r : trial;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= {1'b0, divisor};
  end

  assign done      = done_r;
  assign remainder = rem_r[DW-1:0];

endmodule
`default_nettype wire

// File: rtl/bloom_filter_fnv1a_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_fnv1a_unit
// Bloom filter over a bit memory with seeded FNV-1a hashes, fed one key
// byte per request.
// ----------------------------------------------------------------------------
// A key byte takes, for each of the MAX_HASHES hashes, a pass through the
// shared 32x32 multiplier and a write-back. A last byte then adds, per hash
// in use, a pass through the shared remainder unit, a read and a
// read-modify-write of the bit memory, and then a state to issue the result.
// A clear sweeps the bit memory one word per cycle, then issues the result.
// Busy is high throughout; the single result is a one-cycle strobe that the
// receiver must take. After reset the block runs the same clearing sweep,
// without a result, before taking its first request.
// ----------------------------------------------------------------------------
module bloom_filter_fnv1a_unit #(
  parameter int MAX_FILTER_BITS = 1024,
  parameter int MAX_HASHES      = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_key_byte,
  input  wire logic        in_last_byte,
  output logic             out_strobe,
  output logic [1:0]       out_result_kind,
  output logic             out_maybe_present,
  output logic [15:0]      out_insert_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int BW  = $clog2(MAX_FILTER_BITS + 1);
  localparam int PW  = $clog2(MAX_FILTER_BITS);
  localparam int HW  = $clog2(MAX_HASHES + 1);
  localparam int IW  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int WORDS = (MAX_FILTER_BITS + 31) / 32;
  localparam int AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SW  = (PW > 5) ? PW : 6;

  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_MUL, S_MULW, S_DIV, S_DIVW, S_RD, S_RMW, S_DONE
  } state_t;

  state_t      state_r;
  logic [31:0] hash_r [MAX_HASHES];
  logic [IW-1:0] idx_r;
  logic [HW-1:0] nh_r;
  logic [31:0] prod_r;
  logic [AW:0] wipe_r;
  logic [10:0] fbits_r;
  logic [3:0]  hcnt_r;
  logic [15:0] adds_r;
  logic [1:0]  cmd_r;
  logic [7:0]  byte_r;
  logic        last_r, all_r;
  logic [PW-1:0] pos_r;
  logic [BW-1:0] nbits_r;
  logic [31:0] mem [WORDS];
  logic [31:0] rd_r;
  logic        div_start, div_done;
  logic [BW-1:0] rem;
  logic [4:0]  bsel;
  logic [SW-1:0] posx;

  assign posx = SW'(pos_r);
  assign bsel = posx[4:0];

  bff_divider #(.DW(BW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(hash_r[idx_r]),
    .divisor(nbits_r), .done(div_done), .remainder(rem)
  );

  assign div_start = (state_r == S_DIV);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
      wipe_r  <= '0;
      fbits_r <= 11'd1024;
      hcnt_r  <= 4'd3;
      adds_r  <= '0;
      idx_r   <= '0;
      cmd_r   <= bff_pkg::CMD_NOP;
      out_strobe <= 1'b0;
      for (int i = 0; i < MAX_HASHES; i++) hash_r[i] <= bff_pkg::FNV_BASIS ^ 32'(i);
    end else begin
      out_strobe <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == bff_pkg::REG_FILTER_BITS) fbits_r <= cfg_data[10:0];
        else hcnt_r <= cfg_data[3:0];
      end
      unique case (state_r)
        S_WIPE: begin
          mem[wipe_r[AW-1:0]] <= '0;
          if (wipe_r == (AW+1)'(WORDS - 1)) begin
            state_r <= (cmd_r == bff_pkg::CMD_CLEAR) ? S_DONE : S_IDLE;
          end
          wipe_r <= wipe_r + 1'b1;
        end
        S_IDLE: begin
          if (start && in_command != bff_pkg::CMD_NOP) begin
            cmd_r  <= in_command;
            byte_r <= in_key_byte;
            last_r <= in_last_byte;
            idx_r  <= '0;
            all_r  <= 1'b1;
            if (fbits_r == 11'd0) nbits_r <= BW'(1);
            else if (32'(fbits_r) > MAX_FILTER_BITS) nbits_r <= BW'(MAX_FILTER_BITS);
            else nbits_r <= BW'(fbits_r);
            if (hcnt_r == 4'd0) nh_r <= HW'(1);
            else if (32'(hcnt_r) > MAX_HASHES) nh_r <= HW'(MAX_HASHES);
            else nh_r <= HW'(hcnt_r);
            if (in_command == bff_pkg::CMD_CLEAR) begin
              wipe_r  <= '0;
              adds_r  <= '0;
              state_r <= S_WIPE;
              for (int i = 0; i < MAX_HASHES; i++)
                hash_r[i] <= bff_pkg::FNV_BASIS ^ 32'(i);
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= (hash_r[idx_r] ^ {24'd0, byte_r}) * bff_pkg::FNV_PRIME;
          state_r <= S_MULW;
        end
        S_MULW: begin
          hash_r[idx_r] <= prod_r;
          if (32'(idx_r) == MAX_HASHES - 1) begin
            idx_r   <= '0;
            state_r <= last_r ? S_DIV : S_IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            pos_r   <= PW'(rem);
            state_r <= S_RD;
          end
        end
        S_RD: begin
          rd_r    <= mem[posx[SW-1:5]];
          state_r <= S_RMW;
        end
        S_RMW: begin
          if (cmd_r == bff_pkg::CMD_ADD) begin
            mem[posx[SW-1:5]] <= rd_r | (32'd1 << bsel);
          end else if (!rd_r[bsel]) begin
            all_r <= 1'b0;
          end
          if (HW'(idx_r) + 1'b1 == nh_r) begin
            state_r <= S_DONE;
            if (cmd_r == bff_pkg::CMD_ADD) adds_r <= adds_r + 16'd1;
            for (int i = 0; i < MAX_HASHES; i++)
              hash_r[i] <= bff_pkg::FNV_BASIS ^ 32'(i);
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_DIV;
          end
        end
        S_DONE: begin
          state_r           <= S_IDLE;
          out_strobe        <= 1'b1;
          out_result_kind   <= cmd_r;
          out_maybe_present <= (cmd_r == bff_pkg::CMD_CHECK) && all_r;
          out_insert_count  <= adds_r;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
